// File: sv/strace_pkg.sv
// Shared types, constants and controller encodings for the sequenced trace ring.
`timescale 1ns / 1ps

package strace_pkg;

  // Default sizes, handed to the top level parameters.
  localparam int RingDepthDef = 512;
  localparam int MaxReadDef   = 63;

  // Fixed field widths.
  localparam int SeqW   = 48;
  localparam int TimeW  = 48;
  localparam int LevelW = 3;
  localparam int WordW  = 32;
  localparam int CntW   = 6;

  // Operation codes of an input request.
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // One input request.
  typedef struct packed {
    logic              operation;
    logic [LevelW-1:0] level;
    logic [WordW-1:0]  payload;
    logic [TimeW-1:0]  timestamp;
    logic [SeqW-1:0]   since;
    logic [CntW-1:0]   max_count;
  } in_item_t;

  // One result item: an entry or the closing summary.
  typedef struct packed {
    logic [SeqW-1:0]   entry_seq;
    logic [TimeW-1:0]  entry_time;
    logic [LevelW-1:0] entry_level;
    logic [WordW-1:0]  entry_payload;
    logic [CntW-1:0]   count;
    logic [SeqW-1:0]   next_cursor;
    logic [SeqW-1:0]   dropped;
    logic              last;
  } out_item_t;

  // Word kept in the ring memory for each slot.
  typedef struct packed {
    logic [TimeW-1:0]  time_stamp;
    logic [LevelW-1:0] level;
    logic [WordW-1:0]  payload;
  } ring_word_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OLDEST,
    ST_CLAMP,
    ST_PLACE,
    ST_FETCH,
    ST_SHOW,
    ST_SUMMARY
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic append;       // append request accepted
    logic load_read;    // read request accepted, capture cursor and limit
    logic find_oldest;  // compute oldest held sequence number
    logic clamp;        // clamp start to oldest, record dropped
    logic place;        // compute ring slot of the start entry
    logic fetch;        // issue a ring read and advance the read pointer
    logic advance;      // entry taken, step sequence and count
    logic summary;      // output shows the summary item
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_entries;  // at least one entry to return
    logic more;         // another entry follows the one shown
  } sts_t;

endpackage

// File: sv/strace_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module strace_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/strace_ctrl.sv
// Controller state machine that sequences appends, read setup and result output.
`timescale 1ns / 1ps

module strace_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_op_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output strace_pkg::cmd_t    cmd_o,
  input  strace_pkg::sts_t    sts_i
);

  strace_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= strace_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      strace_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_op_i == strace_pkg::OP_READ) begin
            cmd_o.load_read = 1'b1;
            state_d         = strace_pkg::ST_OLDEST;
          end else begin
            cmd_o.append = 1'b1;
          end
        end
      end
      strace_pkg::ST_OLDEST: begin
        cmd_o.find_oldest = 1'b1;
        state_d           = strace_pkg::ST_CLAMP;
      end
      strace_pkg::ST_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = strace_pkg::ST_PLACE;
      end
      strace_pkg::ST_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = sts_i.has_entries ? strace_pkg::ST_FETCH : strace_pkg::ST_SUMMARY;
      end
      strace_pkg::ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = strace_pkg::ST_SHOW;
      end
      strace_pkg::ST_SHOW: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.advance = 1'b1;
          if (sts_i.more) begin
            // Fetch the following entry so that it shows in the next cycle.
            cmd_o.fetch = 1'b1;
          end else begin
            state_d = strace_pkg::ST_SUMMARY;
          end
        end
      end
      strace_pkg::ST_SUMMARY: begin
        out_valid_o   = 1'b1;
        cmd_o.summary = 1'b1;
        if (!out_stall_i) begin
          state_d = strace_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = strace_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/strace_dp.sv
// Datapath: sequence counter, ring memory, read cursor arithmetic and result fields.
`timescale 1ns / 1ps

module strace_dp #(
  parameter int RING_DEPTH = strace_pkg::RingDepthDef,
  parameter int MAX_READ   = strace_pkg::MaxReadDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  strace_pkg::in_item_t  in_data_i,
  input  strace_pkg::cmd_t      cmd_i,
  output strace_pkg::sts_t      sts_o,
  output strace_pkg::out_item_t out_data_o
);

  localparam int SeqW = strace_pkg::SeqW;
  localparam int CntW = strace_pkg::CntW;
  localparam int PW   = $clog2(RING_DEPTH);

  localparam logic [PW:0]      DepthV   = (PW + 1)'(RING_DEPTH);
  localparam logic [PW-1:0]    LastSlot = PW'(RING_DEPTH - 1);
  localparam logic [SeqW-1:0]  DepthSeq = SeqW'(RING_DEPTH);
  localparam logic [CntW-1:0]  MaxV     = CntW'(MAX_READ);

  // Control state.
  logic              enabled_q;
  logic [SeqW-1:0]   next_seq_q;
  logic [PW-1:0]     wr_ptr_q;

  // Read working registers.
  logic [SeqW:0]     start_q;
  logic [SeqW-1:0]   oldest_q;
  logic [SeqW-1:0]   dropped_q;
  logic [CntW-1:0]   lim_q;
  logic [CntW-1:0]   count_q;
  logic [PW-1:0]     rd_ptr_q;

  logic                   do_append;
  logic [CntW-1:0]        lim_d;
  logic [SeqW-1:0]        oldest_d;
  logic [PW:0]            back_dist;
  logic [PW:0]            wr_wide;
  logic [PW:0]            slot;
  logic [SeqW:0]          start_inc;
  logic [SeqW:0]          nxt_wide;
  logic [CntW:0]          count_inc;
  logic [SeqW:0]          cursor;
  strace_pkg::ring_word_t wdata;
  strace_pkg::ring_word_t rdata;

  assign do_append = cmd_i.append && (in_data_i.operation == strace_pkg::OP_APPEND) && enabled_q;

  // Enable register, sequence counter and write pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q  <= 1'b0;
      next_seq_q <= SeqW'(1);
      wr_ptr_q   <= PW'(1);
    end else begin
      if (cfg_we_i) begin
        enabled_q <= cfg_wdata_i;
      end
      if (do_append) begin
        next_seq_q <= next_seq_q + SeqW'(1);
        // The slot follows the sequence number; a counter wrap restarts at slot zero.
        if (next_seq_q == {SeqW{1'b1}} || wr_ptr_q == LastSlot) begin
          wr_ptr_q <= '0;
        end else begin
          wr_ptr_q <= wr_ptr_q + PW'(1);
        end
      end
    end
  end

  // Ring memory.
  assign wdata.time_stamp = in_data_i.timestamp;
  assign wdata.level      = in_data_i.level;
  assign wdata.payload    = in_data_i.payload;

  strace_ram #(
    .WIDTH ($bits(strace_pkg::ring_word_t)),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_append),
    .waddr_i (wr_ptr_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.fetch),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  // Read setup arithmetic.
  assign lim_d    = (in_data_i.max_count > MaxV) ? MaxV : in_data_i.max_count;
  assign oldest_d = (next_seq_q > DepthSeq) ? (next_seq_q - DepthSeq) : SeqW'(1);
  assign nxt_wide = {1'b0, next_seq_q};

  // Slot of the start entry: back from the write pointer by the distance to it.
  assign back_dist = next_seq_q[PW:0] - start_q[PW:0];
  assign wr_wide   = {1'b0, wr_ptr_q};
  assign slot      = (wr_wide >= back_dist) ? (wr_wide - back_dist)
                                            : (wr_wide + DepthV - back_dist);

  // Stepping through the entries.
  assign start_inc = start_q + (SeqW + 1)'(1);
  assign count_inc = {1'b0, count_q} + (CntW + 1)'(1);

  assign sts_o.has_entries = (start_q < nxt_wide) && (lim_q != '0);
  assign sts_o.more        = (start_inc < nxt_wide) && (count_inc < {1'b0, lim_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_read) begin
      start_q   <= {1'b0, in_data_i.since} + (SeqW + 1)'(1);
      lim_q     <= lim_d;
      count_q   <= '0;
      dropped_q <= '0;
    end
    if (cmd_i.find_oldest) begin
      oldest_q <= oldest_d;
    end
    if (cmd_i.clamp && (start_q < {1'b0, oldest_q})) begin
      dropped_q <= oldest_q - start_q[SeqW-1:0];
      start_q   <= {1'b0, oldest_q};
    end
    if (cmd_i.place) begin
      rd_ptr_q <= slot[PW-1:0];
    end
    if (cmd_i.fetch) begin
      rd_ptr_q <= (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + PW'(1);
    end
    if (cmd_i.advance) begin
      start_q <= start_inc;
      count_q <= count_inc[CntW-1:0];
    end
  end

  // Result fields: an entry while streaming, the summary at the close.
  assign cursor = (start_q == '0) ? '0 : start_q - (SeqW + 1)'(1);

  always_comb begin
    out_data_o = '0;
    if (cmd_i.summary) begin
      out_data_o.count       = count_q;
      out_data_o.next_cursor = cursor[SeqW-1:0];
      out_data_o.dropped     = dropped_q;
      out_data_o.last        = 1'b1;
    end else begin
      out_data_o.entry_seq     = start_q[SeqW-1:0];
      out_data_o.entry_time    = rdata.time_stamp;
      out_data_o.entry_level   = rdata.level;
      out_data_o.entry_payload = rdata.payload;
    end
  end

endmodule

// File: sv/sequenced_trace_ring_unit.sv
// Top level of the sequenced trace ring: controller, datapath and ring memory.
`timescale 1ns / 1ps

// Appends may follow each other in every cycle; while enabled each one is stored under
// the next sequence number, starting at 1, and overwrites the oldest entry once
// RING_DEPTH entries are held. A read request clamps its cursor to the oldest held
// entry in a setup sequence after it is accepted (oldest entry, clamp, slot lookup,
// and a memory fetch only when there is an entry to return), then returns one entry
// per cycle from the registered read port of the ring memory while the output is not
// stalled, and closes with one summary item. No request is accepted until the summary
// item is taken.
// The memory needs no clearing after reset.

module sequenced_trace_ring_unit #(
  parameter int RING_DEPTH = strace_pkg::RingDepthDef,
  parameter int MAX_READ   = strace_pkg::MaxReadDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  strace_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output strace_pkg::out_item_t out_data_o
);

  strace_pkg::cmd_t cmd;
  strace_pkg::sts_t sts;

  // Sequencing of requests.
  strace_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_data_i.operation),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Storage and arithmetic.
  strace_dp #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_READ   (MAX_READ)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

// File: sv/strace_checker.sv
// Port-level assertions for the sequenced trace ring, bound to the top level.
`timescale 1ns / 1ps

module strace_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input strace_pkg::in_item_t  in_data_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input strace_pkg::out_item_t out_data_o
);

  // No request is taken while results of a read are being returned.
  a_busy_while_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("request accepted while results pending");

  // An accepted read request holds off further requests in the next cycle.
  a_read_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.operation == strace_pkg::OP_READ)
      |=> in_stall_o)
    else $error("read request did not hold off the input");

  // After an entry is taken, the next entry follows in order, or the summary
  // reports a cursor equal to the last entry returned.
  a_entry_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_data_o.last)
      |=> out_valid_o &&
          (out_data_o.last ? (out_data_o.next_cursor == $past(out_data_o.entry_seq))
                           : (out_data_o.entry_seq == $past(out_data_o.entry_seq) + 48'd1)))
    else $error("entry sequence or cursor out of order");

  // A taken summary closes the read: nothing is shown in the next cycle.
  a_summary_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.last) |=> !out_valid_o)
    else $error("result shown after summary");

endmodule

bind sequenced_trace_ring_unit strace_checker u_strace_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// File: tb/sequenced_trace_ring_unit_tb.sv
// Self-checking testbench for the sequenced trace ring: directed and random traffic.
`timescale 1ns / 1ps

module sequenced_trace_ring_unit_tb;
  import strace_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int RingDepth   = RingDepthDef;
  localparam int SettleWait  = 8;
  localparam int IdleLimit   = 3000;
  localparam int ReportLimit = 30;
  localparam logic [47:0] SeqMask = 48'hFFFF_FFFF_FFFF;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic      cfg_wdata_i = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  sequenced_trace_ring_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Predicted trace ring contents and register.
  logic            trace_enabled = 1'b0;
  longint unsigned next_seq      = 1;
  logic [47:0]     held_seq     [RingDepth];
  logic [47:0]     held_stamp   [RingDepth];
  logic [2:0]      held_level   [RingDepth];
  logic [31:0]     held_payload [RingDepth];
  longint unsigned reader_cursor = 0;

  // Results still owed by the block, oldest first.
  out_item_t expected_results[$];
  out_item_t observed;
  out_item_t wanted;

  int mismatches      = 0;
  int appends_stored  = 0;
  int appends_ignored = 0;
  int reads_issued    = 0;
  int reads_dropping  = 0;
  int entries_checked = 0;
  int idle_cycles     = 0;
  int burst_left      = 0;
  int stall_mode      = 0;
  int stall_span      = 0;

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  function automatic in_item_t make_append(input logic [2:0] level, input logic [31:0] word,
                                           input logic [47:0] stamp);
    in_item_t req;
    req           = '0;
    req.operation = OP_APPEND;
    req.level     = level;
    req.payload   = word;
    req.timestamp = stamp;
    // Read fields carry noise; the block must ignore them on an append.
    req.since     = rand48();
    req.max_count = 6'($urandom_range(0, 63));
    return req;
  endfunction

  function automatic in_item_t make_read(input longint unsigned cursor, input int unsigned limit);
    in_item_t req;
    req           = '0;
    req.operation = OP_READ;
    req.since     = cursor[47:0];
    req.max_count = limit[5:0];
    // Append fields carry noise on a read.
    req.level     = 3'($urandom_range(0, 7));
    req.payload   = $urandom;
    req.timestamp = rand48();
    return req;
  endfunction

  // Store an append in the predicted ring, if appends are enabled.
  function automatic void record_append(input in_item_t req);
    int unsigned slot;
    if (!trace_enabled) begin
      appends_ignored++;
      return;
    end
    slot               = 32'(next_seq % RingDepth);
    held_seq[slot]     = next_seq[47:0];
    held_stamp[slot]   = req.timestamp;
    held_level[slot]   = req.level;
    held_payload[slot] = req.payload;
    next_seq           = (next_seq + 1) & SeqMask;
    appends_stored++;
  endfunction

  // Work out the entries and the summary that a read returns.
  function automatic void predict_read(input in_item_t req);
    longint unsigned start_seq, oldest_seq, skipped, limit, taken;
    int unsigned     slot;
    out_item_t       res;
    limit = req.max_count;
    if (limit > MaxReadDef) limit = MaxReadDef;
    start_seq = req.since;
    start_seq = start_seq + 1;
    oldest_seq = (next_seq > RingDepth) ? next_seq - RingDepth : 1;
    skipped = 0;
    taken   = 0;
    if (start_seq < oldest_seq) begin
      skipped   = oldest_seq - start_seq;
      start_seq = oldest_seq;
    end
    while (start_seq < next_seq && taken < limit) begin
      slot              = 32'(start_seq % RingDepth);
      res               = '0;
      res.entry_seq     = held_seq[slot];
      res.entry_time    = held_stamp[slot];
      res.entry_level   = held_level[slot];
      res.entry_payload = held_payload[slot];
      expected_results.push_back(res);
      taken++;
      start_seq++;
    end
    res             = '0;
    res.count       = taken[5:0];
    res.next_cursor = 48'(start_seq - 1);
    res.dropped     = skipped[47:0];
    res.last        = 1'b1;
    expected_results.push_back(res);
    reader_cursor = (start_seq - 1) & SeqMask;
    reads_issued++;
    if (skipped != 0) reads_dropping++;
  endfunction

  // Present one request, hold it until accepted, then update the prediction.
  // The sender works in bursts and idles for a random gap between them.
  task automatic send_request(input in_item_t req);
    int gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (req.operation == OP_APPEND) record_append(req);
    else predict_read(req);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 30);
      gap        = $urandom_range(0, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  // Stop sending and wait until every owed result has come out.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  // Write the enable register while the block is idle.
  task automatic set_enabled(input logic value);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    trace_enabled = value;
  endtask

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= ReportLimit)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endfunction

  // Result checker: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && $isunknown(out_valid_o)) begin
      mismatches++;
      $display("%0t: out_valid_o unknown, expected 0x0 or 0x1, actual %b", $time, out_valid_o);
    end else if (rst_ni && out_valid_o && !out_stall_i) begin
      observed = out_data_o;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual 0x%0h", $time, observed);
      end else begin
        wanted = expected_results.pop_front();
        check_field("entry_seq", wanted.entry_seq, observed.entry_seq);
        check_field("entry_time", wanted.entry_time, observed.entry_time);
        check_field("entry_level", wanted.entry_level, observed.entry_level);
        check_field("entry_payload", wanted.entry_payload, observed.entry_payload);
        check_field("count", wanted.count, observed.count);
        check_field("next_cursor", wanted.next_cursor, observed.next_cursor);
        check_field("dropped", wanted.dropped, observed.dropped);
        check_field("last", wanted.last, observed.last);
        if (!wanted.last) entries_checked++;
      end
    end
  end

  // Receiver stall: switches among free flow, light, periodic and heavy stalling.
  always @(negedge clk_i) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_span <= $urandom_range(20, 80);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0: begin
        out_stall_i <= 1'b0;
      end
      1: begin
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
      2: begin
        out_stall_i <= ((stall_span % 7) < 3);
      end
      default: begin
        out_stall_i <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  // Watchdog: give up after a long stretch with no request and no result accepted.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
                 IdleLimit, expected_results.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Straight out of reset: empty ring, appends ignored until enabled.
  task automatic test_reset_state();
    send_request(make_read(0, 63));
    send_request(make_append(3'd7, 32'hFFFF_FFFF, SeqMask));
    send_request(make_append(3'd0, 32'h0, 48'h0));
    send_request(make_read(0, 5));
  endtask

  // Field extremes, zero count, partial reads and cursors at or past the newest entry.
  task automatic test_basic_reads();
    set_enabled(1'b1);
    send_request(make_append(3'd0, 32'h0000_0000, 48'h0));
    send_request(make_append(3'd7, 32'hFFFF_FFFF, SeqMask));
    send_request(make_append(3'd5, 32'hA5A5_5A5A, 48'h1234_5678_9ABC));
    send_request(make_append(3'd2, $urandom, rand48()));
    send_request(make_append(3'd4, $urandom, rand48()));
    send_request(make_read(0, 63));
    send_request(make_read(0, 0));
    send_request(make_read(2, 2));
    send_request(make_read(next_seq - 1, 63));
    send_request(make_read(next_seq + 1000, 63));
    send_request(make_read(SeqMask, 63));
  endtask

  // Reads are still served while appends are switched off.
  task automatic test_read_while_disabled();
    set_enabled(1'b0);
    send_request(make_append(3'd1, $urandom, rand48()));
    send_request(make_read(0, 63));
    set_enabled(1'b1);
  endtask

  // Random traffic in phases; a read follows its own cursor in three of eight cases.
  task automatic test_random_traffic();
    in_item_t        req;
    longint unsigned newest, oldest_seq, cursor;
    int              counted, target;
    for (int phase = 0; phase < 4; phase++) begin
      set_enabled(phase != 2);
      target  = trace_enabled ? 90 : 30;
      counted = 0;
      reader_cursor = (phase == 0) ? 0 : reader_cursor;
      while (counted < target) begin
        if ($urandom_range(0, 99) < 70) begin
          req = make_append(3'($urandom_range(0, 7)), $urandom, rand48());
          if (trace_enabled) counted++;
        end else begin
          newest     = next_seq - 1;
          oldest_seq = (next_seq > RingDepth) ? next_seq - RingDepth : 1;
          case ($urandom_range(0, 7))
            0, 1, 2: cursor = reader_cursor;
            3: cursor = (newest > 70) ? newest - $urandom_range(0, 70)
                                      : $urandom_range(0, int'(newest));
            4: cursor = (oldest_seq > 1) ? $urandom_range(0, int'(oldest_seq) - 2) : 0;
            5: cursor = newest + $urandom_range(0, 3);
            6: cursor = rand48();
            default: cursor = $urandom_range(0, int'(newest));
          endcase
          case ($urandom_range(0, 9))
            0: req = make_read(cursor, 63);
            1, 2: req = make_read(cursor, $urandom_range(0, 63));
            default: req = make_read(cursor, $urandom_range(0, 16));
          endcase
          counted++;
        end
        send_request(req);
        if ($urandom_range(0, 59) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_basic_reads();
    test_read_while_disabled();
    test_random_traffic();
    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Run covered %0d stored and %0d ignored appends, %0d reads, %0d entries checked.",
             appends_stored, appends_ignored, reads_issued, entries_checked);
    $display("%0d reads started behind the oldest held entry; the ring wrapped %0d times.",
             reads_dropping, (next_seq - 1) / RingDepth);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/strace_pkg.sv
sv/strace_ram.sv
sv/strace_ctrl.sv
sv/strace_dp.sv
sv/sequenced_trace_ring_unit.sv
sv/strace_checker.sv
tb/sequenced_trace_ring_unit_tb.sv
